### src/vqc_pkg.sv
// ----------------------------------------------------------------------------
// Vector quantizer codebook package
// Shared operation codes, widths and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
`default_nettype none
package vqc_pkg;

  localparam logic [2:0] OP_LOAD     = 3'd0;
  localparam logic [2:0] OP_CLASSIFY = 3'd1;
  localparam logic [2:0] OP_TRAIN    = 3'd2;
  localparam logic [2:0] OP_ACCUM    = 3'd3;
  localparam logic [2:0] OP_UPDATE   = 3'd4;

  localparam int unsigned SUM_W  = 28;
  localparam int unsigned CODE_W = 16;
  localparam int unsigned DIST_W = 34;
  localparam logic [CODE_W-1:0] CODE_MAX = 16'hFF00;

  localparam logic [2:0] CFG_CENTERS = 3'd0;
  localparam logic [2:0] CFG_DIMS    = 3'd1;
  localparam logic [2:0] CFG_RATE    = 3'd2;

  typedef struct packed {
    logic search_clr;   // clear best distance / winner
    logic search_step;  // compare one codeword distance with the best so far
    logic train_wr;     // write trained winner element
    logic accum_wr;     // add sample to winner sums and count
    logic div_start;    // launch divider for one element
    logic div_wr;       // write quotient to codebook
    logic clr_wr;       // clear sums and count of one codeword
  } vqc_cmd_t;

endpackage
`default_nettype wire

### src/vqc_datapath.sv
// ----------------------------------------------------------------------------
// Vector quantizer datapath
// Holds codebook, cluster sums and counts; runs search, training, accumulate
// and a bit-serial divider for the batch update.
// ----------------------------------------------------------------------------
`default_nettype none
module vqc_datapath
  import vqc_pkg::*;
#(
  parameter int unsigned CENTERS    = 16,
  parameter int unsigned DIM        = 4,
  parameter int unsigned COUNT_BITS = 20,
  parameter int unsigned CW         = (CENTERS > 1) ? $clog2(CENTERS) : 1,
  parameter int unsigned DW         = (DIM > 1) ? $clog2(DIM) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire vqc_cmd_t              cmd,
  input  wire logic [CW-1:0]         center,
  input  wire logic [DW-1:0]         dim,
  input  wire logic [DW:0]           nd,
  input  wire logic [7:0]            learn_rate,
  input  wire logic [4*8-1:0]        samples,
  input  wire logic                  load_wr,
  input  wire logic [4*8-1:0]        load_data,
  output logic [CW-1:0]              best,
  output logic [DIST_W-1:0]          best_dist,
  output logic                       count_zero,
  output logic                       div_done
);

  localparam int unsigned QW = SUM_W + 8;

  logic [DIM*CODE_W-1:0] codebook [CENTERS];
  logic [DIM*SUM_W-1:0]  sums     [CENTERS];
  logic [COUNT_BITS-1:0] counts   [CENTERS];

  logic [CODE_W-1:0] cw_el  [DIM];
  logic [SUM_W-1:0]  sum_el [DIM];
  logic [7:0]        s_el   [DIM];
  logic [DIST_W-1:0] acc;
  logic [COUNT_BITS-1:0] cnt;

  always_comb begin
    for (int d = 0; d < DIM; d++) begin
      cw_el[d]  = codebook[center][d*CODE_W +: CODE_W];
      sum_el[d] = sums[center][d*SUM_W +: SUM_W];
      s_el[d]   = samples[d*8 +: 8];
    end
    cnt = counts[center];
    count_zero = (cnt == '0);
    acc = '0;
    for (int d = 0; d < DIM; d++) begin
      logic signed [17:0] diff;
      logic signed [35:0] sq;
      diff = $signed({2'b00, s_el[d], 8'h00}) - $signed({2'b00, cw_el[d]});
      sq = diff * diff;
      if (d < nd) acc = acc + sq[DIST_W-1:0];
    end
  end

  logic signed [17:0] tdiff;
  logic signed [26:0] tprod;
  logic signed [18:0] tnew;
  always_comb begin
    tdiff = $signed({2'b00, s_el[dim], 8'h00}) - $signed({2'b00, cw_el[dim]});
    tprod = $signed({1'b0, learn_rate}) * tdiff;
    tnew  = $signed({3'b000, cw_el[dim]}) + 19'(tprod >>> 8);
  end

  // bit-serial restoring divider
  logic [QW-1:0]         quo;
  logic [COUNT_BITS:0]   rem;
  logic [$clog2(QW+1)-1:0] dcnt;
  logic [COUNT_BITS:0]   rtry;
  assign rtry = {rem[COUNT_BITS-1:0], quo[QW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CENTERS; i++) begin
        codebook[i] <= '0;
        sums[i]     <= '0;
        counts[i]   <= '0;
      end
      best      <= '0;
      best_dist <= '1;
      quo       <= '0;
      rem       <= '0;
      dcnt      <= '0;
    end else begin
      if (cmd.search_clr) begin
        best <= '0;
        best_dist <= '1;
      end else if (cmd.search_step && acc < best_dist) begin
        best <= center;
        best_dist <= acc;
      end
      if (cmd.train_wr) begin
        if (tnew < 0) codebook[center][dim*CODE_W +: CODE_W] <= '0;
        else if (tnew > $signed({3'b000, CODE_MAX}))
          codebook[center][dim*CODE_W +: CODE_W] <= CODE_MAX;
        else codebook[center][dim*CODE_W +: CODE_W] <= tnew[CODE_W-1:0];
      end
      if (cmd.accum_wr) begin
        for (int d = 0; d < DIM; d++) begin
          logic [SUM_W:0] ns;
          ns = {1'b0, sum_el[d]} + (SUM_W+1)'(s_el[d]);
          if (d < nd) sums[center][d*SUM_W +: SUM_W] <= ns[SUM_W] ? '1 : ns[SUM_W-1:0];
        end
        if (cnt != '1) counts[center] <= cnt + 1'b1;
      end
      if (cmd.clr_wr) begin
        sums[center] <= '0;
        counts[center] <= '0;
      end
      if (cmd.div_start) begin
        quo  <= {sum_el[dim], 8'h00};
        rem  <= '0;
        dcnt <= ($clog2(QW+1))'(QW);
      end else if (dcnt != '0) begin
        dcnt <= dcnt - 1'b1;
        if (rtry >= {1'b0, cnt}) begin
          rem <= rtry - {1'b0, cnt};
          quo <= {quo[QW-2:0], 1'b1};
        end else begin
          rem <= rtry;
          quo <= {quo[QW-2:0], 1'b0};
        end
      end
      if (cmd.div_wr)
        codebook[center][dim*CODE_W +: CODE_W] <=
          (quo > QW'(CODE_MAX)) ? CODE_MAX : quo[CODE_W-1:0];
      if (load_wr) begin
        for (int d = 0; d < DIM; d++)
          codebook[center][d*CODE_W +: CODE_W] <= {load_data[d*8 +: 8], 8'h00};
      end
    end
  end

  assign div_done = (dcnt == '0) && !cmd.div_start;

endmodule
`default_nettype wire

### src/vqc_ctrl.sv
// ----------------------------------------------------------------------------
// Vector quantizer controller
// Sequences search, train, accumulate and batch update over the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module vqc_ctrl
  import vqc_pkg::*;
#(
  parameter int unsigned CENTERS = 16,
  parameter int unsigned DIM     = 4,
  parameter int unsigned CW      = (CENTERS > 1) ? $clog2(CENTERS) : 1,
  parameter int unsigned DW      = (DIM > 1) ? $clog2(DIM) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [2:0]    op_in,
  input  wire logic          loaded,
  input  wire logic [CW:0]   nc,
  input  wire logic [DW:0]   nd,
  input  wire logic [CW-1:0] best,
  input  wire logic          count_zero,
  input  wire logic          div_done,
  output logic               busy,
  output vqc_cmd_t           cmd,
  output logic [CW-1:0]      center,
  output logic [DW-1:0]      dim,
  output logic               done,
  output logic               searched,
  output logic [2:0]         op
);

  localparam logic [2:0] S_IDLE = 3'd0, S_SRCH = 3'd1, S_TRN = 3'd2, S_ACC = 3'd3,
                         S_UCHK = 3'd4, S_UDIV = 3'd5, S_UCLR = 3'd6, S_DONE = 3'd7;

  logic [2:0] state, state_next;
  logic [CW:0] c, c_next;
  logic [DW:0] d, d_next;
  logic started, started_next;

  assign busy = (state != S_IDLE);
  assign center = (state == S_TRN || state == S_ACC) ? best : c[CW-1:0];
  assign dim = d[DW-1:0];

  always_comb begin
    state_next = state;
    c_next = c;
    d_next = d;
    started_next = started;
    cmd = '0;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          c_next = '0;
          d_next = '0;
          started_next = 1'b0;
          cmd.search_clr = 1'b1;
          if ((op_in == OP_CLASSIFY || op_in == OP_TRAIN || op_in == OP_ACCUM) && loaded)
            state_next = S_SRCH;
          else if (op_in == OP_UPDATE) state_next = S_UCHK;
          else state_next = S_DONE;
        end
      end
      S_SRCH: begin
        cmd.search_step = 1'b1;
        if (c + 1'b1 >= nc) begin
          c_next = '0;
          if (op == OP_TRAIN) state_next = S_TRN;
          else if (op == OP_ACCUM) state_next = S_ACC;
          else state_next = S_DONE;
        end else c_next = c + 1'b1;
      end
      S_TRN: begin
        cmd.train_wr = 1'b1;
        if (d + 1'b1 >= nd) state_next = S_DONE;
        else d_next = d + 1'b1;
      end
      S_ACC: begin
        cmd.accum_wr = 1'b1;
        state_next = S_DONE;
      end
      S_UCHK: begin
        if (c >= nc || count_zero) state_next = S_UCLR;
        else begin
          cmd.div_start = 1'b1;
          started_next = 1'b1;
          state_next = S_UDIV;
        end
      end
      S_UDIV: begin
        if (div_done && started) begin
          cmd.div_wr = 1'b1;
          if (d + 1'b1 >= nd) state_next = S_UCLR;
          else begin
            d_next = d + 1'b1;
            state_next = S_UCHK;
          end
        end
      end
      S_UCLR: begin
        cmd.clr_wr = 1'b1;
        started_next = 1'b0;
        d_next = '0;
        if (c == (CW+1)'(CENTERS - 1)) state_next = S_DONE;
        else begin
          c_next = c + 1'b1;
          state_next = S_UCHK;
        end
      end
      S_DONE: begin
        done = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      c <= '0;
      d <= '0;
      started <= 1'b0;
      op <= '0;
      searched <= 1'b0;
    end else begin
      state <= state_next;
      c <= c_next;
      d <= d_next;
      started <= started_next;
      if (state == S_IDLE && start) begin
        op <= op_in;
        searched <= (op_in == OP_CLASSIFY || op_in == OP_TRAIN || op_in == OP_ACCUM);
      end
    end
  end

endmodule
`default_nettype wire

### src/vector_quantizer_codebook_top.sv
// ----------------------------------------------------------------------------
// Vector quantizer codebook top level
// An item is classified by the distance search over the effective
// centers_in_use codewords, one codeword per cycle, and then trained over
// the effective dims_in_use elements or accumulated once. Batch update walks
// all CENTERS codewords: an empty or unused one is only cleared; one with
// samples sends each used element through a 36-step bit-serial divider and
// is then cleared. Load and unused ops go straight to done. The result
// appears for one cycle on done; the receiver cannot stall it.
// ----------------------------------------------------------------------------
`default_nettype none
module vector_quantizer_codebook_top
  import vqc_pkg::*;
#(
  parameter int unsigned CENTERS    = 16,
  parameter int unsigned DIM        = 4,
  parameter int unsigned COUNT_BITS = 20
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  op,
  input  wire logic [3:0]  code_index,
  input  wire logic [7:0]  sample0,
  input  wire logic [7:0]  sample1,
  input  wire logic [7:0]  sample2,
  input  wire logic [7:0]  sample3,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic             done,
  output logic [3:0]       winner,
  output logic [33:0]      min_sq_distance,
  output logic             status
);

  localparam int unsigned CW = (CENTERS > 1) ? $clog2(CENTERS) : 1;
  localparam int unsigned DW = (DIM > 1) ? $clog2(DIM) : 1;

  logic [4:0] centers_in_use;
  logic [2:0] dims_in_use;
  logic [7:0] learn_rate;
  logic       loaded;
  logic       loaded_at_start;
  logic [31:0] samples;
  logic [2:0] op_q;
  logic [CW:0] nc;
  logic [DW:0] nd;
  vqc_cmd_t cmd;
  logic [CW-1:0] center, best;
  logic [DW-1:0] dim;
  logic [DIST_W-1:0] best_dist;
  logic count_zero, div_done, searched, load_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      centers_in_use <= 5'd16;
      dims_in_use <= 3'd3;
      learn_rate <= 8'd26;
    end else if (cfg_we) begin
      case ({1'b0, cfg_index})
        CFG_CENTERS: centers_in_use <= cfg_data[4:0];
        CFG_DIMS:    dims_in_use <= cfg_data[2:0];
        CFG_RATE:    learn_rate <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (centers_in_use == '0) nc = (CW+1)'(1);
    else if (32'(centers_in_use) > CENTERS) nc = (CW+1)'(CENTERS);
    else nc = (CW+1)'(centers_in_use);
    if (dims_in_use == '0) nd = (DW+1)'(1);
    else if (32'(dims_in_use) > DIM) nd = (DW+1)'(DIM);
    else nd = (DW+1)'(dims_in_use);
  end

  assign load_hit = start && !busy && op == OP_LOAD && 32'(code_index) < CENTERS;

  always_ff @(posedge clk) begin
    if (rst) loaded <= 1'b0;
    else if (load_hit) loaded <= 1'b1;
    if (start && !busy) samples <= {sample3, sample2, sample1, sample0};
  end

  vqc_ctrl #(.CENTERS(CENTERS), .DIM(DIM)) u_ctrl (
    .clk, .rst, .start, .op_in(op), .loaded, .nc, .nd, .best, .count_zero, .div_done,
    .busy, .cmd, .center, .dim, .done, .searched, .op(op_q)
  );

  vqc_datapath #(.CENTERS(CENTERS), .DIM(DIM), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk, .rst, .cmd, .center(load_hit ? CW'(code_index) : center), .dim, .nd, .learn_rate,
    .samples, .load_wr(load_hit), .load_data({sample3, sample2, sample1, sample0}),
    .best, .best_dist, .count_zero, .div_done
  );

  always_comb begin
    winner = '0;
    min_sq_distance = '0;
    status = 1'b0;
    if (searched) begin
      if (!loaded_at_start) status = 1'b1;
      else begin
        winner = 4'(best);
        min_sq_distance = best_dist;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) loaded_at_start <= 1'b0;
    else if (start && !busy) loaded_at_start <= loaded;
  end

  property p_start_busy;
    @(posedge clk) disable iff (rst) (start && !busy) |=> busy;
  endproperty
  a_start_busy: assert property (p_start_busy) else $error("busy not raised");

  property p_done_ends;
    @(posedge clk) disable iff (rst) done |=> !busy;
  endproperty
  a_done_ends: assert property (p_done_ends) else $error("busy after done");

  property p_status_clean;
    @(posedge clk) disable iff (rst) (done && status) |-> (winner == '0 && min_sq_distance == '0);
  endproperty
  a_status_clean: assert property (p_status_clean) else $error("status with result");

endmodule
`default_nettype wire
